// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the scheduler RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is held.
`define PTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold.
`define PTS_NEVER(lbl, clk, rst_n, expr, msg) \
  `PTS_ASSERT(lbl, clk, rst_n, !(expr), msg)

`endif

// ----- rtl/pts_pkg.sv -----
// Package for the priority task scheduler: codes, defaults and cell link types.
// No dependencies.
package pts_pkg;

  localparam int MAX_TASKS_DEF = 8;
  localparam int MAX_SEMS_DEF  = 8;
  localparam int IDX_W         = 6;

  localparam logic [5:0] IDLE_PRIO = 6'd63;

  localparam logic [1:0] MODE_READY   = 2'd0;
  localparam logic [1:0] MODE_DELAYED = 2'd1;
  localparam logic [1:0] MODE_PENDING = 2'd2;

  localparam logic [3:0] FN_CREATE   = 4'd0;
  localparam logic [3:0] FN_RUN      = 4'd1;
  localparam logic [3:0] FN_DELAY    = 4'd2;
  localparam logic [3:0] FN_TICK     = 4'd3;
  localparam logic [3:0] FN_ISR_IN   = 4'd4;
  localparam logic [3:0] FN_ISR_OUT  = 4'd5;
  localparam logic [3:0] FN_SEM_NEW  = 4'd6;
  localparam logic [3:0] FN_PEND     = 4'd7;
  localparam logic [3:0] FN_POST     = 4'd8;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SLOT  = 2'd1;
  localparam logic [1:0] ST_NO_SEM   = 2'd2;
  localparam logic [1:0] ST_IDLE_BLK = 2'd3;

  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_CREATE = 3'd1;
  localparam logic [2:0] CMD_DELAY  = 3'd2;
  localparam logic [2:0] CMD_PEND   = 3'd3;
  localparam logic [2:0] CMD_WAKE   = 3'd4;
  localparam logic [2:0] CMD_TICK   = 3'd5;

  // Running best-so-far handed from cell to cell.
  typedef struct packed {
    logic             rdy_found;
    logic [5:0]       rdy_prio;
    logic [IDX_W-1:0] rdy_idx;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             pnd_found;
    logic [5:0]       pnd_prio;
    logic [IDX_W-1:0] pnd_idx;
  } link_t;

  // Update broadcast to all cells.
  typedef struct packed {
    logic [2:0]       op;
    logic [IDX_W-1:0] idx;
    logic [5:0]       prio;
    logic [15:0]      dly;
    logic [2:0]       sem;
  } cmd_t;

endpackage

// ----- rtl/pts_if.sv -----
// Request and response channel interfaces of the scheduler.
// No dependencies.
interface pts_req_if;
  logic               valid;
  logic               ready;
  logic [3:0]         func;
  logic [5:0]         priority_req;
  logic [15:0]        delay_ticks;
  logic [2:0]         sem_index;
  logic signed [15:0] sem_initial;
  modport source (output valid, func, priority_req, delay_ticks, sem_index, sem_initial,
                  input ready);
  modport sink (input valid, func, priority_req, delay_ticks, sem_index, sem_initial,
                output ready);
endinterface

interface pts_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  running_slot;
  logic        running_valid;
  logic        switched;
  logic [2:0]  new_handle;
  logic [1:0]  status;
  logic [31:0] switch_count;
  logic [31:0] tick_count;
  modport source (output valid, running_slot, running_valid, switched, new_handle, status,
                  switch_count, tick_count, input ready);
  modport sink (input valid, running_slot, running_valid, switched, new_handle, status,
                switch_count, tick_count, output ready);
endinterface

// ----- rtl/priority_task_scheduler_unit.sv -----
// Priority-preemptive task scheduler: control, semaphore store, output register.
// Depends on pts_pkg, pts_if, pts_cell and assert_macros.svh.
//
// Usage:
//   in_req  : one kernel request per handshake (func, priority_req, delay_ticks,
//             sem_index, sem_initial). Accepted when valid and ready are high.
//   out_rsp : exactly one response per request, in order, held in an output
//             register until the receiver takes it.
// Timing: each request runs as search pass, apply, search pass, dispatch.
//   A search pass walks the registered row of MAX_TASKS slot cells, one cell
//   per cycle. One request is in flight at a time; in_req.ready is high only
//   while the control is idle, also while a response still waits.
// Stall: if the receiver holds off, the finished request waits in dispatch
//   until the output register frees up; nothing is lost or repeated.
// Reset (rst_n low, synchronous): slot 0 is the idle task at priority 63, other
//   slots free, all semaphores free, other counters zero, no task running.
//   Semaphore counts are undefined until created; no clearing pass is needed.
`include "assert_macros.svh"
module priority_task_scheduler_unit #(
  parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF,
  parameter int MAX_SEMS  = pts_pkg::MAX_SEMS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  pts_req_if.sink   in_req,
  pts_rsp_if.source out_rsp
);

  localparam int TW  = $clog2(MAX_TASKS);
  localparam int SAW = (MAX_SEMS > 1) ? $clog2(MAX_SEMS) : 1;
  localparam int FW  = $clog2(MAX_SEMS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH1 = 3'd1;
  localparam logic [2:0] S_APPLY = 3'd2;
  localparam logic [2:0] S_SRCH2 = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [TW-1:0] cnt_r;

  // latched request
  logic [3:0]         fn_r;
  logic [5:0]         prio_r;
  logic [15:0]        dly_r;
  logic [2:0]         si_r;
  logic signed [15:0] init_r;

  // kernel state outside the cells
  logic [FW-1:0] sems_free_r;
  logic [2:0]    cur_slot_r;
  logic          cur_valid_r;
  logic          run_started_r;
  logic [7:0]    isr_nest_r;
  logic [31:0]   sw_count_r;
  logic [31:0]   tick_count_r;
  logic [2:0]    handle_r, handle_nxt;
  logic [1:0]    status_r, status_nxt;

  // semaphore counts, no reset
  logic signed [15:0] sem_mem [MAX_SEMS];
  logic signed [15:0] sem_rd_r;

  // response register
  logic        out_valid_r;
  logic [2:0]  o_slot_r;
  logic        o_rvalid_r;
  logic        o_sw_r;
  logic [2:0]  o_handle_r;
  logic [1:0]  o_status_r;
  logic [31:0] o_swcnt_r;
  logic [31:0] o_ticks_r;

  pts_pkg::link_t lnk [MAX_TASKS+1];
  pts_pkg::cmd_t  cmd;
  pts_pkg::link_t chain_out;

  logic in_fire, done_go, si_ok, sem_we;
  logic [SAW-1:0] sem_wa, in_sa;
  logic signed [15:0] sem_wd;
  logic [FW-1:0] free_idx;
  logic [2:0] t_top;
  logic sw_now;
  logic sw_take;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign done_go      = (state_r == S_DONE) && !(out_valid_r && !out_rsp.ready);
  assign chain_out    = lnk[MAX_TASKS];
  assign lnk[0]       = '0;
  assign si_ok        = ({29'd0, si_r} < 32'(MAX_SEMS));
  assign free_idx     = sems_free_r - FW'(1);
  assign in_sa        = SAW'(in_req.sem_index);
  assign t_top        = 3'(chain_out.rdy_idx);
  assign sw_now       = !cur_valid_r || (t_top != cur_slot_r);
  assign sw_take      = run_started_r && (isr_nest_r == 8'd0) && sw_now;

  // row of slot cells
  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    pts_cell #(.IDX(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .srch_sem (si_r),
      .lnk_in   (lnk[g]),
      .lnk_out  (lnk[g+1])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_SRCH1;
      S_SRCH1: if (cnt_r == TW'(MAX_TASKS - 1)) state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_SRCH2;
      S_SRCH2: if (cnt_r == TW'(MAX_TASKS - 1)) state_nxt = S_DONE;
      S_DONE:  if (done_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // operation decode; acts only in apply, using the first search pass
  always_comb begin
    cmd        = '0;
    sem_we     = 1'b0;
    sem_wa     = SAW'(si_r);
    sem_wd     = sem_rd_r;
    handle_nxt = 3'd0;
    status_nxt = pts_pkg::ST_OK;
    if (state_r == S_APPLY) begin
      unique case (fn_r)
        pts_pkg::FN_CREATE: begin
          if (chain_out.free_found) begin
            cmd.op     = pts_pkg::CMD_CREATE;
            cmd.idx    = chain_out.free_idx;
            cmd.prio   = prio_r;
            handle_nxt = 3'(chain_out.free_idx);
          end else status_nxt = pts_pkg::ST_NO_SLOT;
        end
        pts_pkg::FN_DELAY: begin
          if (chain_out.rdy_idx != '0) begin
            cmd.op  = pts_pkg::CMD_DELAY;
            cmd.idx = chain_out.rdy_idx;
            cmd.dly = (dly_r == 16'd0) ? 16'd1 : dly_r;
          end else status_nxt = pts_pkg::ST_IDLE_BLK;
        end
        pts_pkg::FN_TICK: cmd.op = pts_pkg::CMD_TICK;
        pts_pkg::FN_SEM_NEW: begin
          if (sems_free_r != '0) begin
            sem_we     = 1'b1;
            sem_wa     = free_idx[SAW-1:0];
            sem_wd     = init_r;
            handle_nxt = 3'(free_idx);
          end else status_nxt = pts_pkg::ST_NO_SEM;
        end
        pts_pkg::FN_PEND: if (si_ok) begin
          if (sem_rd_r > 16'sd0) begin
            sem_we = 1'b1;
            sem_wd = sem_rd_r - 16'sd1;
          end else if (chain_out.rdy_idx != '0) begin
            sem_we  = (sem_rd_r != 16'sh8000);
            sem_wd  = sem_rd_r - 16'sd1;
            cmd.op  = pts_pkg::CMD_PEND;
            cmd.idx = chain_out.rdy_idx;
            cmd.sem = si_r;
          end else status_nxt = pts_pkg::ST_IDLE_BLK;
        end
        pts_pkg::FN_POST: if (si_ok) begin
          sem_we = (sem_rd_r != 16'sh7FFF);
          sem_wd = sem_rd_r + 16'sd1;
          if (sem_rd_r[15] && chain_out.pnd_found) begin
            cmd.op  = pts_pkg::CMD_WAKE;
            cmd.idx = chain_out.pnd_idx;
          end
        end
        default: ;
      endcase
    end
  end

  // semaphore store: read at accept, write in apply
  always_ff @(posedge clk) begin
    if (in_fire) sem_rd_r <= sem_mem[in_sa];
    if (sem_we)  sem_mem[sem_wa] <= sem_wd;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fn_r   <= in_req.func;
      prio_r <= in_req.priority_req;
      dly_r  <= in_req.delay_ticks;
      si_r   <= in_req.sem_index;
      init_r <= in_req.sem_initial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      sems_free_r   <= FW'(MAX_SEMS);
      cur_slot_r    <= 3'd0;
      cur_valid_r   <= 1'b0;
      run_started_r <= 1'b0;
      isr_nest_r    <= 8'd0;
      sw_count_r    <= 32'd0;
      tick_count_r  <= 32'd0;
      handle_r      <= 3'd0;
      status_r      <= pts_pkg::ST_OK;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (state_r == S_SRCH1 || state_r == S_SRCH2) && state_nxt == state_r ?
                 cnt_r + TW'(1) : '0;

      if (state_r == S_APPLY) begin
        handle_r <= handle_nxt;
        status_r <= status_nxt;
        unique case (fn_r)
          pts_pkg::FN_RUN: run_started_r <= 1'b1;
          pts_pkg::FN_TICK: tick_count_r <= tick_count_r + 32'd1;
          pts_pkg::FN_ISR_IN:
            if (isr_nest_r != 8'hFF) isr_nest_r <= isr_nest_r + 8'd1;
          pts_pkg::FN_ISR_OUT:
            if (isr_nest_r != 8'd0) isr_nest_r <= isr_nest_r - 8'd1;
          pts_pkg::FN_SEM_NEW:
            if (sems_free_r != '0) sems_free_r <= free_idx;
          default: ;
        endcase
      end

      // dispatch from the second search pass; counters are captured with the
      // response so a later request cannot change a waiting one
      if (done_go) begin
        if (run_started_r && isr_nest_r == 8'd0) begin
          cur_slot_r  <= t_top;
          cur_valid_r <= 1'b1;
          o_slot_r    <= t_top;
          o_rvalid_r  <= 1'b1;
          if (sw_now) sw_count_r <= sw_count_r + 32'd1;
        end else begin
          o_slot_r   <= cur_slot_r;
          o_rvalid_r <= cur_valid_r;
        end
        o_sw_r      <= sw_take;
        o_swcnt_r   <= sw_count_r + {31'd0, sw_take};
        o_ticks_r   <= tick_count_r;
        o_handle_r  <= handle_r;
        o_status_r  <= status_r;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.running_slot  = o_slot_r;
  assign out_rsp.running_valid = o_rvalid_r;
  assign out_rsp.switched      = o_sw_r;
  assign out_rsp.new_handle    = o_handle_r;
  assign out_rsp.status        = o_status_r;
  assign out_rsp.switch_count  = o_swcnt_r;
  assign out_rsp.tick_count    = o_ticks_r;

  // idle task is always ready, so every finished pass finds a ready slot
  `PTS_ASSERT(a_ready_found, clk, rst_n,
    (state_r == S_APPLY || state_r == S_DONE) |-> chain_out.rdy_found,
    "search pass found no ready slot")
  `PTS_ASSERT(a_done_out, clk, rst_n, done_go |=> out_valid_r,
    "dispatched request left no response")
  `PTS_NEVER(a_valid_fell, clk, rst_n, $fell(cur_valid_r),
    "running task marker dropped")
  `PTS_NEVER(a_sems_free, clk, rst_n, (32'(sems_free_r) > 32'(MAX_SEMS)),
    "free semaphore count out of range")

endmodule

// ----- rtl/pts_cell.sv -----
// One task slot cell: slot state, broadcast update and registered search link.
// Depends on pts_pkg.
module pts_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pts_pkg::cmd_t  cmd,
  input  logic [2:0]     srch_sem,
  input  pts_pkg::link_t lnk_in,
  output pts_pkg::link_t lnk_out
);

  localparam logic [pts_pkg::IDX_W-1:0] MY_IDX = pts_pkg::IDX_W'(IDX);

  logic        used_r;
  logic [5:0]  prio_r;
  logic [1:0]  mode_r;
  logic [15:0] dly_r;
  logic [2:0]  wsem_r;
  logic [15:0] dly_dec;
  logic        hit;
  pts_pkg::link_t lnk_nxt;

  assign hit     = (cmd.idx == MY_IDX);
  assign dly_dec = (dly_r != 16'd0) ? dly_r - 16'd1 : 16'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= (IDX == 0);
      prio_r <= (IDX == 0) ? pts_pkg::IDLE_PRIO : 6'd0;
      mode_r <= pts_pkg::MODE_READY;
      dly_r  <= 16'd0;
      wsem_r <= 3'd0;
    end else begin
      unique case (cmd.op)
        pts_pkg::CMD_CREATE: if (hit) begin
          used_r <= 1'b1;
          prio_r <= cmd.prio;
          mode_r <= pts_pkg::MODE_READY;
          dly_r  <= 16'd0;
          wsem_r <= 3'd0;
        end
        pts_pkg::CMD_DELAY: if (hit) begin
          mode_r <= pts_pkg::MODE_DELAYED;
          dly_r  <= cmd.dly;
        end
        pts_pkg::CMD_PEND: if (hit) begin
          mode_r <= pts_pkg::MODE_PENDING;
          wsem_r <= cmd.sem;
        end
        pts_pkg::CMD_WAKE: if (hit) begin
          mode_r <= pts_pkg::MODE_READY;
        end
        pts_pkg::CMD_TICK: if (used_r && mode_r == pts_pkg::MODE_DELAYED) begin
          dly_r <= dly_dec;
          if (dly_dec == 16'd0) mode_r <= pts_pkg::MODE_READY;
        end
        default: ;
      endcase
    end
  end

  // Strict compare keeps the lower slot on equal priority.
  always_comb begin
    lnk_nxt = lnk_in;
    if (used_r && mode_r == pts_pkg::MODE_READY &&
        (!lnk_in.rdy_found || prio_r < lnk_in.rdy_prio)) begin
      lnk_nxt.rdy_found = 1'b1;
      lnk_nxt.rdy_prio  = prio_r;
      lnk_nxt.rdy_idx   = MY_IDX;
    end
    if (!used_r && !lnk_in.free_found) begin
      lnk_nxt.free_found = 1'b1;
      lnk_nxt.free_idx   = MY_IDX;
    end
    if (used_r && mode_r == pts_pkg::MODE_PENDING && wsem_r == srch_sem &&
        (!lnk_in.pnd_found || prio_r < lnk_in.pnd_prio)) begin
      lnk_nxt.pnd_found = 1'b1;
      lnk_nxt.pnd_prio  = prio_r;
      lnk_nxt.pnd_idx   = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    lnk_out <= lnk_nxt;
  end

endmodule

// ----- sim/pts_sched_checker.sv -----
`timescale 1ns / 100ps
// Response checker for the priority task scheduler: tracks kernel state per request
// and compares every response. Depends on pts_pkg and pts_if.
module pts_sched_checker (
  input  logic      clk,
  input  logic      rst_n,
  pts_req_if        req,
  pts_rsp_if        rsp,
  output int        mismatches,
  output int        outstanding
);

  localparam int NTASK = pts_pkg::MAX_TASKS_DEF;
  localparam int NSEM  = pts_pkg::MAX_SEMS_DEF;

  typedef struct packed {
    logic [2:0]  slot;
    logic        slot_vld;
    logic        sw;
    logic [2:0]  handle;
    logic [1:0]  status;
    logic [31:0] sw_cnt;
    logic [31:0] tick_cnt;
  } sched_rsp_t;

  sched_rsp_t rsp_q[$];

  logic        used[NTASK];
  logic [5:0]  prio[NTASK];
  logic [1:0]  mode[NTASK];
  logic [15:0] dly_left[NTASK];
  logic [2:0]  wait_sem[NTASK];
  int          sem_cnt[NSEM];
  int          sems_left;
  logic [2:0]  cur_slot;
  logic        cur_vld;
  logic        started;
  int          nest;
  logic [31:0] sw_total;
  logic [31:0] ticks;

  assign outstanding = rsp_q.size();

  function automatic int best_ready();
    int best;
    int bp;
    best = 0;
    bp = 64;
    for (int i = 0; i < NTASK; i++)
      if (used[i] && mode[i] == pts_pkg::MODE_READY && int'(prio[i]) < bp) begin
        bp = int'(prio[i]);
        best = i;
      end
    return best;
  endfunction

  function automatic sched_rsp_t schedule(input logic [3:0] f, input logic [5:0] p,
                                          input logic [15:0] d, input logic [2:0] si,
                                          input logic signed [15:0] init);
    sched_rsp_t r;
    int t;
    int slot;
    int bp;
    int found;
    r = '0;
    unique case (f)
      pts_pkg::FN_CREATE: begin
        slot = NTASK;
        for (int i = NTASK - 1; i >= 0; i--) if (!used[i]) slot = i;
        if (slot == NTASK) r.status = pts_pkg::ST_NO_SLOT;
        else begin
          used[slot] = 1'b1;
          prio[slot] = p;
          mode[slot] = pts_pkg::MODE_READY;
          dly_left[slot] = '0;
          wait_sem[slot] = '0;
          r.handle = 3'(slot);
        end
      end
      pts_pkg::FN_RUN: started = 1'b1;
      pts_pkg::FN_DELAY: begin
        t = best_ready();
        if (t == 0) r.status = pts_pkg::ST_IDLE_BLK;
        else begin
          mode[t] = pts_pkg::MODE_DELAYED;
          dly_left[t] = (d == 16'd0) ? 16'd1 : d;
        end
      end
      pts_pkg::FN_TICK: begin
        ticks++;
        for (int i = 0; i < NTASK; i++)
          if (used[i] && mode[i] == pts_pkg::MODE_DELAYED) begin
            if (dly_left[i] != 16'd0) dly_left[i]--;
            if (dly_left[i] == 16'd0) mode[i] = pts_pkg::MODE_READY;
          end
      end
      pts_pkg::FN_ISR_IN: if (nest < 255) nest++;
      pts_pkg::FN_ISR_OUT: if (nest > 0) nest--;
      pts_pkg::FN_SEM_NEW: begin
        if (sems_left == 0) r.status = pts_pkg::ST_NO_SEM;
        else begin
          sems_left--;
          sem_cnt[sems_left] = int'(init);
          r.handle = 3'(sems_left);
        end
      end
      pts_pkg::FN_PEND: begin
        if (sem_cnt[si] > 0) sem_cnt[si]--;
        else begin
          t = best_ready();
          if (t == 0) r.status = pts_pkg::ST_IDLE_BLK;
          else begin
            if (sem_cnt[si] > -32768) sem_cnt[si]--;
            mode[t] = pts_pkg::MODE_PENDING;
            wait_sem[t] = si;
          end
        end
      end
      pts_pkg::FN_POST: begin
        if (sem_cnt[si] < 32767) sem_cnt[si]++;
        // old count negative means someone may be waiting
        if (sem_cnt[si] <= 0) begin
          bp = 64;
          found = NTASK;
          for (int i = 0; i < NTASK; i++)
            if (used[i] && mode[i] == pts_pkg::MODE_PENDING && wait_sem[i] == si &&
                int'(prio[i]) < bp) begin
              bp = int'(prio[i]);
              found = i;
            end
          if (found < NTASK) mode[found] = pts_pkg::MODE_READY;
        end
      end
      default: ;
    endcase
    if (started && nest == 0) begin
      t = best_ready();
      if (!cur_vld || 3'(t) != cur_slot) begin
        sw_total++;
        r.sw = 1'b1;
      end
      cur_slot = 3'(t);
      cur_vld = 1'b1;
    end
    r.slot = cur_slot;
    r.slot_vld = cur_vld;
    r.sw_cnt = sw_total;
    r.tick_cnt = ticks;
    return r;
  endfunction

  task automatic compare(input string fld, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch %s: expected %0h got %0h", $realtime, fld, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    sched_rsp_t e;
    if (!rst_n) begin
      mismatches = 0;
      rsp_q.delete();
      for (int i = 0; i < NTASK; i++) begin
        used[i] = (i == 0);
        prio[i] = (i == 0) ? pts_pkg::IDLE_PRIO : 6'd0;
        mode[i] = pts_pkg::MODE_READY;
        dly_left[i] = '0;
        wait_sem[i] = '0;
      end
      for (int i = 0; i < NSEM; i++) sem_cnt[i] = 0;
      sems_left = NSEM;
      cur_slot = '0;
      cur_vld = 1'b0;
      started = 1'b0;
      nest = 0;
      sw_total = '0;
      ticks = '0;
    end else begin
      if (req.valid && req.ready)
        rsp_q.push_back(schedule(req.func, req.priority_req, req.delay_ticks,
                                 req.sem_index, req.sem_initial));
      if (rsp.valid && rsp.ready) begin
        if (rsp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t response with no request pending", $realtime);
        end else begin
          e = rsp_q.pop_front();
          compare("running_slot", 32'(e.slot), 32'(rsp.running_slot));
          compare("running_valid", 32'(e.slot_vld), 32'(rsp.running_valid));
          compare("switched", 32'(e.sw), 32'(rsp.switched));
          compare("new_handle", 32'(e.handle), 32'(rsp.new_handle));
          compare("status", 32'(e.status), 32'(rsp.status));
          compare("switch_count", e.sw_cnt, rsp.switch_count);
          compare("tick_count", e.tick_cnt, rsp.tick_count);
        end
      end
    end
  end
endmodule

// ----- sim/priority_task_scheduler_unit_test.sv -----
`timescale 1ns / 100ps
// Testbench top for priority_task_scheduler_unit: drives kernel requests, paces
// both channels and gives the verdict. Depends on pts_pkg, pts_if, pts_sched_checker.
module priority_task_scheduler_unit_test;

  localparam int IDLE_LIMIT = 4000;  // cycles with no handshake before giving up
  localparam int STALL_LEN  = 300;   // long receiver hold-off

  logic clk;
  logic rst_n;
  int   send_idle;
  int   rcv_idle;
  int   stall_req;
  int   stall_done;
  int   mismatches;
  int   outstanding;
  int   quiet_cycles;

  pts_req_if in_req();
  pts_rsp_if out_rsp();

  priority_task_scheduler_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req.sink),
    .out_rsp(out_rsp.source)
  );

  pts_sched_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (in_req),
    .rsp        (out_rsp),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Watchdog: any handshake restarts the count.
  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready) || !rst_n)
      quiet_cycles <= 0;
    else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Receiver: random ready, or one long hold-off each time one is asked for.
  initial begin
    out_rsp.ready = 1'b0;
    stall_done = 0;
    forever begin
      @(posedge clk);
      if (stall_req != stall_done) begin
        stall_done = stall_req;
        out_rsp.ready <= 1'b0;
        repeat (STALL_LEN - 1) @(posedge clk);
      end else
        out_rsp.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // One request; valid stays up across back-to-back requests.
  task automatic issue(input logic [3:0] f, input logic [5:0] p, input logic [15:0] d,
                       input logic [2:0] s, input logic [15:0] v);
    if ($urandom_range(99) < send_idle) begin
      in_req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_req.valid <= 1'b1;
    in_req.func <= f;
    in_req.priority_req <= p;
    in_req.delay_ticks <= d;
    in_req.sem_index <= s;
    in_req.sem_initial <= v;
    do @(posedge clk); while (!in_req.ready);
  endtask

  // Random kernel traffic; all semaphores exist by now, tick-heavy so delays expire.
  task automatic random_ops(input int n);
    int pick;
    logic [3:0] f;
    logic [15:0] d;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 28) f = pts_pkg::FN_TICK;
      else if (pick < 42) f = pts_pkg::FN_DELAY;
      else if (pick < 56) f = pts_pkg::FN_PEND;
      else if (pick < 74) f = pts_pkg::FN_POST;
      else if (pick < 80) f = pts_pkg::FN_ISR_IN;
      else if (pick < 87) f = pts_pkg::FN_ISR_OUT;
      else if (pick < 89) f = pts_pkg::FN_CREATE;
      else if (pick < 90) f = pts_pkg::FN_RUN;
      else if (pick < 91) f = pts_pkg::FN_SEM_NEW;
      else if (pick < 96) f = 4'($urandom_range(15, 9));  // unused codes
      else f = pts_pkg::FN_TICK;
      pick = $urandom_range(29);
      if (pick == 0) d = 16'($urandom_range(65535));
      else if (pick < 6) d = 16'($urandom_range(40));
      else d = 16'($urandom_range(4));
      issue(f, 6'($urandom_range(62)), d, 3'($urandom_range(7)), 16'($urandom));
    end
  endtask

  initial begin
    in_req.valid = 1'b0;
    in_req.func = pts_pkg::FN_TICK;
    in_req.priority_req = '0;
    in_req.delay_ticks = '0;
    in_req.sem_index = '0;
    in_req.sem_initial = '0;
    send_idle = 21;
    rcv_idle = 59;
    stall_req = 0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: before run, nothing dispatches.
    issue(pts_pkg::FN_ISR_OUT, 6'd0, 16'd0, 3'd0, 16'h0);   // exit with no nesting
    issue(pts_pkg::FN_DELAY, 6'd0, 16'd5, 3'd0, 16'h0);     // only idle ready: illegal block
    issue(pts_pkg::FN_CREATE, 6'd62, 16'd0, 3'd0, 16'h0);
    issue(pts_pkg::FN_CREATE, 6'd0, 16'd0, 3'd0, 16'h0);
    issue(pts_pkg::FN_CREATE, 6'd31, 16'd0, 3'd0, 16'h0);
    issue(pts_pkg::FN_CREATE, 6'd10, 16'd0, 3'd0, 16'h0);
    issue(pts_pkg::FN_CREATE, 6'd10, 16'd0, 3'd0, 16'h0);   // duplicate priority
    issue(pts_pkg::FN_CREATE, 6'd20, 16'd0, 3'd0, 16'h0);
    issue(pts_pkg::FN_CREATE, 6'd40, 16'd0, 3'd0, 16'h0);
    issue(pts_pkg::FN_CREATE, 6'd5, 16'd0, 3'd0, 16'h0);    // table full
    issue(pts_pkg::FN_RUN, 6'd0, 16'd0, 3'd0, 16'h0);
    issue(pts_pkg::FN_RUN, 6'd0, 16'd0, 3'd0, 16'h0);       // second run is a no-op
    issue(pts_pkg::FN_SEM_NEW, 6'd0, 16'd0, 3'd0, 16'h7FFF);
    issue(pts_pkg::FN_SEM_NEW, 6'd0, 16'd0, 3'd0, 16'h8000);
    for (int i = 0; i < 6; i++)
      issue(pts_pkg::FN_SEM_NEW, 6'd0, 16'd0, 3'd0, 16'(i) - 16'd2);
    issue(pts_pkg::FN_SEM_NEW, 6'd0, 16'd0, 3'd0, 16'h1);   // no semaphore left
    issue(pts_pkg::FN_POST, 6'd0, 16'd0, 3'd7, 16'h0);      // saturate at max
    issue(pts_pkg::FN_PEND, 6'd0, 16'd0, 3'd6, 16'h0);      // at min, blocks, stays min
    issue(pts_pkg::FN_POST, 6'd0, 16'd0, 3'd6, 16'h0);      // wakes the waiter
    issue(pts_pkg::FN_DELAY, 6'd0, 16'd0, 3'd0, 16'h0);     // zero means one tick
    issue(pts_pkg::FN_DELAY, 6'd0, 16'hFFFF, 3'd0, 16'h0);
    issue(pts_pkg::FN_TICK, 6'd0, 16'd0, 3'd0, 16'h0);
    issue(pts_pkg::FN_ISR_IN, 6'd0, 16'd0, 3'd0, 16'h0);
    issue(pts_pkg::FN_TICK, 6'd0, 16'd0, 3'd0, 16'h0);      // no dispatch inside ISR
    issue(pts_pkg::FN_ISR_OUT, 6'd0, 16'd0, 3'd0, 16'h0);
    issue(4'd15, 6'd0, 16'd0, 3'd0, 16'h0);

    random_ops(200);
    stall_req++;                                           // fill the block, input must stall
    random_ops(250);

    send_idle = 59;
    rcv_idle = 21;
    random_ops(300);

    send_idle = 0;
    rcv_idle = 0;
    random_ops(150);
    repeat (260) issue(pts_pkg::FN_ISR_IN, 6'd0, 16'd0, 3'd0, 16'($urandom));  // nest saturates
    repeat (260) issue(pts_pkg::FN_ISR_OUT, 6'd0, 16'd0, 3'd0, 16'($urandom));
    stall_req++;
    random_ops(250);
    in_req.valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule

// ----- priority_task_scheduler_unit.f -----
+incdir+rtl
rtl/pts_pkg.sv
rtl/pts_if.sv
rtl/pts_cell.sv
rtl/priority_task_scheduler_unit.sv
sim/pts_sched_checker.sv
sim/priority_task_scheduler_unit_test.sv
